// ===== rtl/mau_pkg.sv =====
package mau_pkg;

    localparam int DATA_W = 64;
    localparam int WIDTH_DEF = 64;
    localparam logic [DATA_W-1:0] MOD_RESET = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int NRES_LIMIT = 4096;
    localparam int NRES_W = 13;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_POW  = 3'd4;
    localparam logic [2:0] OP_SQRT = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOINV  = 2'd1;
    localparam logic [1:0] ST_NONRES = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_MUL,
        S_FIN_MUL,
        S_FIN_POW,
        S_DIV_FIN,
        S_POW_SQ,
        S_POW_SQD,
        S_POW_MD,
        S_POW_STEP,
        S_INV_TEST,
        S_INV_DIV,
        S_INV_UPD,
        S_SQ_START,
        S_SQ_EULER,
        S_SQ_FACT,
        S_SQ_W,
        S_SQ_WCHK,
        S_SQ_WQ,
        S_SQ_R,
        S_SQ_AINV,
        S_SQ_RND,
        S_SQ_Y1,
        S_SQ_Y2,
        S_SQ_ORD,
        S_SQ_ORDM,
        S_SQ_B,
        S_SQ_BM,
        S_SQ_RM,
        S_DONE
    } state_t;

endpackage

// ===== rtl/mau_modmul.sv =====
module mau_modmul #(
    parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic [WIDTH-1:0] m,
    output logic             done,
    output logic [WIDTH-1:0] p
);
    import mau_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] dbl;

    // (a + b) mod m for a, b < m
    function automatic logic [WIDTH-1:0] modadd(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] md);
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, md};
        return (s >= {1'b0, md}) ? d[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

    // MSB-first shift-and-add, one multiplier bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        dbl       = modadd(acc_reg, acc_reg, m_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            m_next    = m;
        end
        else if (busy_reg)
        begin
            acc_next = y_reg[WIDTH-1] ? modadd(dbl, x_reg, m_reg) : dbl;
            y_next   = y_reg << 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ===== rtl/mau_divu.sv =====
module mau_divu #(
    parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mau_pkg::DATA_W-1:0] num,
    input  logic [WIDTH-1:0]          den,
    output logic                      done,
    output logic [mau_pkg::DATA_W-1:0] quo,
    output logic [WIDTH-1:0]          rem
);
    import mau_pkg::*;

    localparam int CW = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0] n_reg, n_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH-1:0]  den_reg, den_next;
    logic [WIDTH:0]    trial;
    logic [WIDTH:0]    diff;
    logic              ge;

    // restoring division; quotient bits shift in as numerator bits shift out
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, n_reg[DATA_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DATA_W);
            n_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_next   = {n_reg[DATA_W-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = n_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit over a programmable prime modulus.
//
// Config: cfg_we/cfg_wdata write the modulus (low WIDTH bits kept); write only
// while busy is low. Reset loads 2^64-59, masked to WIDTH bits.
// Request: req is taken on a rising edge with start high and busy low. busy
// stays high until the result has been shown; further starts are ignored.
// Response: rsp is valid for exactly one cycle with done high. The receiver
// cannot stall, so the result must be captured in that cycle.
//
// Flow: both operands are first reduced by the bit-serial divider, unless the
// modulus is below 3, which ends the request at once. Every modular product
// goes through the shared shift-add multiplier. Add/sub need no product, mul
// one, pow up to 2*WIDTH products, div a divide plus a product per Euclid step
// and a final product if the inverse exists, sqrt several exponentiations plus
// the Tonelli-Shanks rounds. One request at a time; the multiplier is the limit.
// Reset returns the sequencer to idle; no request is in flight afterwards.
module modular_arithmetic_unit #(
    parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mau_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                       start,
    input  mau_pkg::req_t              req,
    output logic                       busy,
    output logic                       done,
    output mau_pkg::rsp_t              rsp
);
    import mau_pkg::*;

    localparam int SW = $clog2(WIDTH + 1);

    state_t state_reg, state_next;
    state_t mul_ret_reg, mul_ret_next;
    state_t pow_ret_reg, pow_ret_next;
    state_t inv_ret_reg, inv_ret_next;

    logic [WIDTH-1:0]  m_reg;
    logic [2:0]        op_reg, op_next;
    logic [DATA_W-1:0] braw_reg, braw_next;
    logic [WIDTH-1:0]  a_reg, a_next;
    logic [WIDTH-1:0]  b_reg, b_next;
    logic [WIDTH-1:0]  res_reg, res_next;
    logic [1:0]        st_reg, st_next;
    logic [WIDTH-1:0]  acc_reg, acc_next;
    logic [WIDTH-1:0]  base_reg, base_next;
    logic [WIDTH-1:0]  exp_reg, exp_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [WIDTH-1:0]  q_reg, q_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [WIDTH-1:0]  w_reg, w_next;
    logic [NRES_W-1:0] wcnt_reg, wcnt_next;
    logic [WIDTH-1:0]  r_reg, r_next;
    logic [WIDTH-1:0]  ainv_reg, ainv_next;
    logic [WIDTH-1:0]  y_reg, y_next;
    logic [WIDTH-1:0]  bb_reg, bb_next;
    logic [SW-1:0]     i_reg, i_next;
    logic [SW-1:0]     j_reg, j_next;
    logic [SW-1:0]     rnd_reg, rnd_next;
    logic [WIDTH-1:0]  r0_reg, r0_next;
    logic [WIDTH-1:0]  r1_reg, r1_next;
    logic [WIDTH-1:0]  t0_reg, t0_next;
    logic [WIDTH-1:0]  t1_reg, t1_next;

    logic              mul_start;
    logic [WIDTH-1:0]  mul_x, mul_y, mul_p;
    logic              mul_done;
    logic              div_start;
    logic [DATA_W-1:0] div_num, div_q;
    logic [WIDTH-1:0]  div_den, div_r;
    logic              div_done;

    logic [WIDTH-1:0]  m_half, m_less1, quo_w, quo_m;
    logic [SW:0]       b_lhs, b_rhs;

    function automatic logic [WIDTH-1:0] modadd(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] md);
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, md};
        return (s >= {1'b0, md}) ? d[WIDTH-1:0] : s[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] modsub(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] md);
        return (a >= b) ? (a - b) : (a + (md - b));
    endfunction

    mau_modmul #(.WIDTH(WIDTH)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (m_reg),
        .done  (mul_done),
        .p     (mul_p)
    );

    mau_divu #(.WIDTH(WIDTH)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .rem   (div_r)
    );

    assign m_half  = m_reg >> 1;
    assign m_less1 = m_reg - WIDTH'(1);
    assign quo_w   = div_q[WIDTH-1:0];
    // Euclid quotient never exceeds the modulus, one subtract reduces it
    assign quo_m   = (quo_w >= m_reg) ? (quo_w - m_reg) : quo_w;
    assign b_lhs   = {1'b0, j_reg} + (SW + 1)'(1);
    assign b_rhs   = {1'b0, s_reg} - {1'b0, i_reg};

    // sequencer: next state, subroutine returns, datapath and unit commands
    always_comb
    begin
        state_next   = state_reg;
        mul_ret_next = mul_ret_reg;
        pow_ret_next = pow_ret_reg;
        inv_ret_next = inv_ret_reg;
        op_next      = op_reg;
        braw_next    = braw_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        k_next       = k_reg;
        q_next       = q_reg;
        s_next       = s_reg;
        w_next       = w_reg;
        wcnt_next    = wcnt_reg;
        r_next       = r_reg;
        ainv_next    = ainv_reg;
        y_next       = y_reg;
        bb_next      = bb_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        rnd_next     = rnd_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        mul_start    = 1'b0;
        mul_x        = '0;
        mul_y        = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = m_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req.op;
                    braw_next = req.operand_b;
                    res_next  = '0;
                    st_next   = ST_OK;
                    if (m_reg < WIDTH'(3))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = req.operand_a;
                        state_next = S_RED_A;
                    end
                end
            end
            S_RED_A:
            begin
                if (div_done)
                begin
                    a_next     = div_r;
                    div_start  = 1'b1;
                    div_num    = braw_reg;
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (div_done)
                begin
                    b_next     = div_r;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        res_next   = modadd(a_reg, b_reg, m_reg);
                        state_next = S_DONE;
                    end
                    OP_SUB:
                    begin
                        res_next   = modsub(a_reg, b_reg, m_reg);
                        state_next = S_DONE;
                    end
                    OP_MUL:
                    begin
                        mul_start    = 1'b1;
                        mul_x        = a_reg;
                        mul_y        = b_reg;
                        mul_ret_next = S_FIN_MUL;
                        state_next   = S_MUL;
                    end
                    OP_DIV:
                    begin
                        r0_next      = m_reg;
                        r1_next      = b_reg;
                        t0_next      = '0;
                        t1_next      = WIDTH'(1);
                        inv_ret_next = S_DIV_FIN;
                        state_next   = S_INV_TEST;
                    end
                    OP_POW:
                    begin
                        base_next    = a_reg;
                        exp_next     = b_reg;
                        acc_next     = WIDTH'(1);
                        k_next       = SW'(WIDTH);
                        pow_ret_next = S_FIN_POW;
                        state_next   = S_POW_SQ;
                    end
                    OP_SQRT:
                    begin
                        state_next = S_SQ_START;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = mul_ret_reg;
                end
            end
            S_FIN_MUL:
            begin
                res_next   = mul_p;
                state_next = S_DONE;
            end
            S_FIN_POW:
            begin
                res_next   = acc_reg;
                state_next = S_DONE;
            end
            S_DIV_FIN:
            begin
                if (r0_reg == WIDTH'(1))
                begin
                    mul_start    = 1'b1;
                    mul_x        = a_reg;
                    mul_y        = t0_reg;
                    mul_ret_next = S_FIN_MUL;
                    state_next   = S_MUL;
                end
                else
                begin
                    res_next   = '0;
                    st_next    = ST_NOINV;
                    state_next = S_DONE;
                end
            end
            // square-and-multiply, exponent scanned MSB first
            S_POW_SQ:
            begin
                mul_start    = 1'b1;
                mul_x        = acc_reg;
                mul_y        = acc_reg;
                mul_ret_next = S_POW_SQD;
                state_next   = S_MUL;
            end
            S_POW_SQD:
            begin
                acc_next = mul_p;
                if (exp_reg[WIDTH-1])
                begin
                    mul_start    = 1'b1;
                    mul_x        = mul_p;
                    mul_y        = base_reg;
                    mul_ret_next = S_POW_MD;
                    state_next   = S_MUL;
                end
                else
                begin
                    state_next = S_POW_STEP;
                end
            end
            S_POW_MD:
            begin
                acc_next   = mul_p;
                state_next = S_POW_STEP;
            end
            S_POW_STEP:
            begin
                exp_next = exp_reg << 1;
                k_next   = k_reg - SW'(1);
                if (k_reg == SW'(1))
                begin
                    state_next = pow_ret_reg;
                end
                else
                begin
                    state_next = S_POW_SQ;
                end
            end
            // extended Euclid; inverse ends in t0, gcd in r0
            S_INV_TEST:
            begin
                if (r1_reg == '0)
                begin
                    state_next = inv_ret_reg;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DATA_W'(r0_reg);
                    div_den    = r1_reg;
                    state_next = S_INV_DIV;
                end
            end
            S_INV_DIV:
            begin
                div_den = r1_reg;
                if (div_done)
                begin
                    r0_next      = r1_reg;
                    r1_next      = div_r;
                    mul_start    = 1'b1;
                    mul_x        = quo_m;
                    mul_y        = t1_reg;
                    mul_ret_next = S_INV_UPD;
                    state_next   = S_MUL;
                end
            end
            S_INV_UPD:
            begin
                t0_next    = t1_reg;
                t1_next    = modsub(t0_reg, mul_p, m_reg);
                state_next = S_INV_TEST;
            end
            S_SQ_START:
            begin
                if (a_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (!m_reg[0])
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    base_next    = a_reg;
                    exp_next     = m_half;
                    acc_next     = WIDTH'(1);
                    k_next       = SW'(WIDTH);
                    pow_ret_next = S_SQ_EULER;
                    state_next   = S_POW_SQ;
                end
            end
            S_SQ_EULER:
            begin
                if (acc_reg != WIDTH'(1))
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else if (m_reg[1])
                begin
                    // modulus = 3 mod 4: root is a^((m+1)/4)
                    base_next    = a_reg;
                    exp_next     = (m_reg >> 2) + WIDTH'(1);
                    acc_next     = WIDTH'(1);
                    k_next       = SW'(WIDTH);
                    pow_ret_next = S_FIN_POW;
                    state_next   = S_POW_SQ;
                end
                else
                begin
                    q_next     = m_less1;
                    s_next     = '0;
                    state_next = S_SQ_FACT;
                end
            end
            S_SQ_FACT:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    s_next = s_reg + SW'(1);
                end
                else
                begin
                    w_next     = WIDTH'(2);
                    wcnt_next  = '0;
                    state_next = S_SQ_W;
                end
            end
            S_SQ_W:
            begin
                if ((w_reg >= m_reg) || (wcnt_reg == NRES_W'(NRES_LIMIT)))
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    base_next    = w_reg;
                    exp_next     = m_half;
                    acc_next     = WIDTH'(1);
                    k_next       = SW'(WIDTH);
                    pow_ret_next = S_SQ_WCHK;
                    state_next   = S_POW_SQ;
                end
            end
            S_SQ_WCHK:
            begin
                if (acc_reg == m_less1)
                begin
                    base_next    = w_reg;
                    exp_next     = q_reg;
                    acc_next     = WIDTH'(1);
                    k_next       = SW'(WIDTH);
                    pow_ret_next = S_SQ_WQ;
                    state_next   = S_POW_SQ;
                end
                else
                begin
                    w_next     = w_reg + WIDTH'(1);
                    wcnt_next  = wcnt_reg + NRES_W'(1);
                    state_next = S_SQ_W;
                end
            end
            S_SQ_WQ:
            begin
                w_next       = acc_reg;
                base_next    = a_reg;
                exp_next     = (q_reg >> 1) + WIDTH'(1);
                acc_next     = WIDTH'(1);
                k_next       = SW'(WIDTH);
                pow_ret_next = S_SQ_R;
                state_next   = S_POW_SQ;
            end
            S_SQ_R:
            begin
                r_next       = acc_reg;
                r0_next      = m_reg;
                r1_next      = a_reg;
                t0_next      = '0;
                t1_next      = WIDTH'(1);
                inv_ret_next = S_SQ_AINV;
                state_next   = S_INV_TEST;
            end
            S_SQ_AINV:
            begin
                if (r0_reg != WIDTH'(1))
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    ainv_next  = t0_reg;
                    rnd_next   = '0;
                    state_next = S_SQ_RND;
                end
            end
            S_SQ_RND:
            begin
                if (rnd_reg > s_reg)
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    mul_start    = 1'b1;
                    mul_x        = r_reg;
                    mul_y        = r_reg;
                    mul_ret_next = S_SQ_Y1;
                    state_next   = S_MUL;
                end
            end
            S_SQ_Y1:
            begin
                mul_start    = 1'b1;
                mul_x        = mul_p;
                mul_y        = ainv_reg;
                mul_ret_next = S_SQ_Y2;
                state_next   = S_MUL;
            end
            S_SQ_Y2:
            begin
                y_next     = mul_p;
                i_next     = '0;
                state_next = S_SQ_ORD;
            end
            // order of y: square until it reaches one
            S_SQ_ORD:
            begin
                if (y_reg == WIDTH'(1))
                begin
                    if (i_reg == '0)
                    begin
                        res_next   = r_reg;
                        state_next = S_DONE;
                    end
                    else if (i_reg >= s_reg)
                    begin
                        st_next    = ST_NONRES;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bb_next    = w_reg;
                        j_next     = '0;
                        state_next = S_SQ_B;
                    end
                end
                else if (i_reg >= s_reg)
                begin
                    st_next    = ST_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next       = i_reg + SW'(1);
                    mul_start    = 1'b1;
                    mul_x        = y_reg;
                    mul_y        = y_reg;
                    mul_ret_next = S_SQ_ORDM;
                    state_next   = S_MUL;
                end
            end
            S_SQ_ORDM:
            begin
                y_next     = mul_p;
                state_next = S_SQ_ORD;
            end
            S_SQ_B:
            begin
                mul_start = 1'b1;
                mul_y     = bb_reg;
                if (b_lhs < b_rhs)
                begin
                    mul_x        = bb_reg;
                    mul_ret_next = S_SQ_BM;
                end
                else
                begin
                    mul_x        = r_reg;
                    mul_ret_next = S_SQ_RM;
                end
                state_next = S_MUL;
            end
            S_SQ_BM:
            begin
                bb_next    = mul_p;
                j_next     = j_reg + SW'(1);
                state_next = S_SQ_B;
            end
            S_SQ_RM:
            begin
                r_next     = mul_p;
                rnd_next   = rnd_reg + SW'(1);
                state_next = S_SQ_RND;
            end
            S_DONE:
            begin
                if (st_reg != ST_OK)
                begin
                    res_next = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // port outputs
    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        done        = (state_reg == S_DONE);
        rsp.result  = (st_reg != ST_OK) ? '0 : DATA_W'(res_reg);
        rsp.status  = st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mul_ret_reg <= S_IDLE;
            pow_ret_reg <= S_IDLE;
            inv_ret_reg <= S_IDLE;
            m_reg       <= MOD_RESET[WIDTH-1:0];
            st_reg      <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            mul_ret_reg <= mul_ret_next;
            pow_ret_reg <= pow_ret_next;
            inv_ret_reg <= inv_ret_next;
            st_reg      <= st_next;
            if (cfg_we)
            begin
                m_reg <= cfg_wdata[WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        braw_reg <= braw_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        k_reg    <= k_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        w_reg    <= w_next;
        wcnt_reg <= wcnt_next;
        r_reg    <= r_next;
        ainv_reg <= ainv_next;
        y_reg    <= y_next;
        bb_reg   <= bb_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        rnd_reg  <= rnd_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
    end

endmodule

// ===== rtl/mau_checker.sv =====
module mau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input mau_pkg::rsp_t rsp
);
    import mau_pkg::*;

    // an accepted request keeps the unit busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // result strobe only while a request is in flight
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a request");

    // one result per request
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("unit still busy after result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK) || (rsp.status == ST_NOINV)
                 || (rsp.status == ST_NONRES))
        else $error("bad status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_OK) |-> (rsp.result == '0))
        else $error("nonzero result with error status");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
